### src/ofw_pkg.sv
// Shared constants, codes and queue entry type for the framebuffer window writer.
`default_nettype none
package ofw_pkg;

  // Display geometry
  localparam int COLUMNS    = 128;
  localparam int PAGE_COUNT = 8;
  localparam int STORE_SIZE = COLUMNS * PAGE_COUNT;
  localparam int IDX_W      = $clog2(STORE_SIZE);

  // Width of the page * COLUMNS + column product (9-bit page, 8-bit column count)
  localparam int CALC_W = 17;

  // Control bytes
  localparam logic [7:0] CTRL_COMMAND = 8'h00;
  localparam logic [7:0] CTRL_DATA    = 8'h40;

  // Window commands
  localparam logic [7:0] CMD_SET_COLUMN = 8'h21;
  localparam logic [7:0] CMD_SET_PAGE   = 8'h22;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_W     = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    OP_NONE,
    OP_WRITE,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] mem_addr;
    logic [7:0]       wdata;
    logic [9:0]       store_address;
    logic             frame_update;
    logic             bad_control;
  } entry_t;

endpackage
`default_nettype wire

### src/ofw_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module ofw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one word; read data holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

### src/ofw_front.sv
// Front end: accepts bytes, tracks transaction mode, windows and cursors, queues work.
`default_nettype none
module ofw_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          cmd,
  input  wire logic [7:0]    data_byte,
  input  wire logic          first_byte,
  input  wire logic          last_byte,
  input  wire logic [9:0]    read_address,
  input  wire logic          queue_full,
  input  wire logic          clearing,
  output logic               in_stall,
  output logic               push,
  output ofw_pkg::entry_t    push_entry
);
  import ofw_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_COMMAND,
    MODE_DATA
  } mode_t;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_COLUMN,
    PEND_PAGE
  } pend_t;

  mode_t       mode, mode_next;
  pend_t       pend, pend_next;
  logic        arg_seen, arg_seen_next;
  logic [7:0]  first_arg, first_arg_next;
  logic [7:0]  col_first, col_first_next;
  logic [7:0]  col_last, col_last_next;
  logic [7:0]  page_first, page_first_next;
  logic [7:0]  page_last, page_last_next;
  logic [8:0]  col, col_next;
  logic [8:0]  page, page_next;

  logic              accept;
  logic              in_display;
  logic [CALC_W-1:0] store_idx;
  logic [CALC_W-1:0] read_idx;
  logic [8:0]        col_inc;
  logic [8:0]        page_inc;

  assign in_stall = clearing || queue_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept;

  // Cursor address and range checks
  assign in_display = (page < 9'(PAGE_COUNT)) && (col < 9'(COLUMNS));
  assign store_idx  = CALC_W'(page) * CALC_W'(COLUMNS) + CALC_W'(col);
  assign read_idx   = CALC_W'(read_address);
  assign col_inc    = col + 9'd1;
  assign page_inc   = page + 9'd1;

  // Classify the byte and compute next state
  always_comb begin
    mode_next       = mode;
    pend_next       = pend;
    arg_seen_next   = arg_seen;
    first_arg_next  = first_arg;
    col_first_next  = col_first;
    col_last_next   = col_last;
    page_first_next = page_first;
    page_last_next  = page_last;
    col_next        = col;
    page_next       = page;
    push_entry      = '0;
    push_entry.op   = OP_NONE;

    priority if (cmd) begin
      if (read_idx < CALC_W'(STORE_SIZE)) begin
        push_entry.op       = OP_READ;
        push_entry.mem_addr = read_idx[IDX_W-1:0];
      end
    end else if (first_byte) begin
      pend_next     = PEND_NONE;
      arg_seen_next = 1'b0;
      priority if (data_byte == CTRL_COMMAND) begin
        mode_next = MODE_COMMAND;
      end else if (data_byte == CTRL_DATA) begin
        mode_next = MODE_DATA;
      end else begin
        mode_next              = MODE_IDLE;
        push_entry.bad_control = 1'b1;
      end
      if (last_byte) begin
        push_entry.frame_update = (mode_next == MODE_DATA);
        mode_next               = MODE_IDLE;
      end
    end else begin
      priority if (mode == MODE_COMMAND) begin
        priority if (pend == PEND_NONE) begin
          if (data_byte == CMD_SET_COLUMN) begin
            pend_next     = PEND_COLUMN;
            arg_seen_next = 1'b0;
          end else if (data_byte == CMD_SET_PAGE) begin
            pend_next     = PEND_PAGE;
            arg_seen_next = 1'b0;
          end
        end else if (!arg_seen) begin
          first_arg_next = data_byte;
          arg_seen_next  = 1'b1;
        end else begin
          if (pend == PEND_COLUMN) begin
            col_first_next = first_arg;
            col_last_next  = data_byte;
            col_next       = {1'b0, first_arg};
          end else begin
            page_first_next = first_arg;
            page_last_next  = data_byte;
            page_next       = {1'b0, first_arg};
          end
          pend_next     = PEND_NONE;
          arg_seen_next = 1'b0;
        end
      end else if (mode == MODE_DATA) begin
        if (in_display) begin
          push_entry.op            = OP_WRITE;
          push_entry.mem_addr      = store_idx[IDX_W-1:0];
          push_entry.wdata         = data_byte;
          push_entry.store_address = store_idx[9:0];
        end
        // Advance column, wrap into the next page, wrap the page window
        if (col_inc > {1'b0, col_last}) begin
          col_next = {1'b0, col_first};
          if (page_inc > {1'b0, page_last}) begin
            page_next = {1'b0, page_first};
          end else begin
            page_next = page_inc;
          end
        end else begin
          col_next = col_inc;
        end
        push_entry.frame_update = last_byte;
      end else begin
        // Idle: drop the byte
        mode_next = MODE_IDLE;
      end
      if (last_byte) begin
        mode_next     = MODE_IDLE;
        pend_next     = PEND_NONE;
        arg_seen_next = 1'b0;
      end
    end
  end

  // Hold transaction state, windows and cursors
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      pend       <= PEND_NONE;
      arg_seen   <= 1'b0;
      first_arg  <= 8'd0;
      col_first  <= 8'd0;
      col_last   <= 8'(COLUMNS - 1);
      page_first <= 8'd0;
      page_last  <= 8'(PAGE_COUNT - 1);
      col        <= 9'd0;
      page       <= 9'd0;
    end else if (accept) begin
      mode       <= mode_next;
      pend       <= pend_next;
      arg_seen   <= arg_seen_next;
      first_arg  <= first_arg_next;
      col_first  <= col_first_next;
      col_last   <= col_last_next;
      page_first <= page_first_next;
      page_last  <= page_last_next;
      col        <= col_next;
      page       <= page_next;
    end
  end

endmodule
`default_nettype wire

### src/ofw_queue.sv
// Short FIFO of classified work between front and back.
`default_nettype none
module ofw_queue (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  ofw_pkg::entry_t push_entry,
  input  wire logic       pop,
  output ofw_pkg::entry_t pop_entry,
  output logic            full,
  output logic            empty
);
  import ofw_pkg::*;

  entry_t             slots [QUEUE_DEPTH];
  logic [QUEUE_W-1:0] wr_ptr;
  logic [QUEUE_W-1:0] rd_ptr;
  logic [QUEUE_W:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full      = (count == (QUEUE_W + 1)'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign pop_entry = slots[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QUEUE_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QUEUE_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (QUEUE_W + 1)'(1);
        2'b01:   count <= count - (QUEUE_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### src/ofw_back.sv
// Back end: clears the framebuffer after reset, performs writes and reads, holds results.
`default_nettype none
module ofw_back (
  input  wire logic       clk,
  input  wire logic       rst,
  input  ofw_pkg::entry_t q_entry,
  input  wire logic       q_empty,
  output logic            q_pop,
  output logic            clearing,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            stored,
  output logic [9:0]      store_address,
  output logic [7:0]      read_data,
  output logic            frame_update,
  output logic            bad_control
);
  import ofw_pkg::*;

  logic [IDX_W-1:0] clr_idx;
  entry_t           res;
  logic             ram_we;
  logic             ram_re;
  logic [IDX_W-1:0] ram_addr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;

  // Take the next entry when the result register is free or draining
  assign q_pop = !q_empty && !clearing && (!out_valid || !out_stall);

  // Clearing pass owns the port; otherwise the popped entry does
  assign ram_we    = clearing || (q_pop && (q_entry.op == OP_WRITE));
  assign ram_re    = q_pop && (q_entry.op == OP_READ);
  assign ram_addr  = clearing ? clr_idx : q_entry.mem_addr;
  assign ram_wdata = clearing ? 8'd0 : q_entry.wdata;

  ofw_ram #(
    .WIDTH (8),
    .DEPTH (STORE_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Sweep the framebuffer to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == IDX_W'(STORE_SIZE - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res <= q_entry;
    end
  end

  // Drive result fields
  always_comb begin
    stored        = 1'b0;
    read_data     = 8'd0;
    store_address = res.store_address;
    frame_update  = res.frame_update;
    bad_control   = res.bad_control;
    unique case (res.op)
      OP_WRITE: stored    = 1'b1;
      OP_READ:  read_data = ram_rdata;
      default:  stored    = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

### src/oled_framebuffer_window_writer_top.sv
// Top level of the display framebuffer window writer.
//
// Input channel (in_valid / in_stall): one bus transaction byte per transaction with
// first_byte and last_byte marks, or with cmd high a read of one framebuffer byte at
// read_address. Output channel (out_valid / out_stall): exactly one result per input
// transaction, in order: stored and store_address for a data byte written, read_data
// for a read, frame_update at the end of a data transfer, bad_control for a bad
// control byte.
// Throughput is one transaction per cycle while in_stall is low: mode, window and cursor
// updates finish in the cycle a byte is taken, and the single framebuffer RAM port serves
// one write or read per cycle. A taken input is written into the queue, then popped into
// the result register, where out_valid rises.
// A four-entry queue parts the input side from the result register, so the queue and
// the result register absorb up to five transactions while the receiver stalls; then
// in_stall rises.
// After reset the framebuffer is swept to zero, one byte a cycle, over all 1024 bytes
// (COLUMNS * PAGE_COUNT); in_stall stays high until the sweep ends.
`default_nettype none
module oled_framebuffer_window_writer_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       cmd,
  input  wire logic [7:0] data_byte,
  input  wire logic       first_byte,
  input  wire logic       last_byte,
  input  wire logic [9:0] read_address,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            stored,
  output logic [9:0]      store_address,
  output logic [7:0]      read_data,
  output logic            frame_update,
  output logic            bad_control
);
  import ofw_pkg::*;

  entry_t push_entry;
  entry_t pop_entry;
  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  logic   clearing;

  ofw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .cmd          (cmd),
    .data_byte    (data_byte),
    .first_byte   (first_byte),
    .last_byte    (last_byte),
    .read_address (read_address),
    .queue_full   (full),
    .clearing     (clearing),
    .in_stall     (in_stall),
    .push         (push),
    .push_entry   (push_entry)
  );

  ofw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .full       (full),
    .empty      (empty)
  );

  ofw_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_entry       (pop_entry),
    .q_empty       (empty),
    .q_pop         (pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .stored        (stored),
    .store_address (store_address),
    .read_data     (read_data),
    .frame_update  (frame_update),
    .bad_control   (bad_control)
  );

endmodule
`default_nettype wire

### src/ofw_checker.sv
// Port-level checker for the framebuffer window writer, bound to the top level.
`default_nettype none
module ofw_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       stored,
  input wire logic [9:0] store_address,
  input wire logic [7:0] read_data,
  input wire logic       frame_update,
  input wire logic       bad_control
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(stored) && $stable(store_address)
      && $stable(read_data) && $stable(frame_update) && $stable(bad_control))
    else $error("stalled result changed");

  // Framebuffer is being cleared right after reset
  a_clear_stall: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input taken during clearing pass");

  // Store address is zero unless a byte was stored
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !stored |-> store_address == 10'd0)
    else $error("store address without store");

  // Read data only comes with a result that carries nothing else
  a_read_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_data != 8'd0 |-> !stored && !frame_update && !bad_control)
    else $error("read data mixed with other result fields");

  // A bad control byte never stores
  a_bad_no_store: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_control |-> !stored && !frame_update)
    else $error("bad control byte stored or updated frame");

endmodule

bind oled_framebuffer_window_writer_top ofw_checker u_ofw_checker (.*);
`default_nettype wire
